>>> rtl/core/gda_pkg.sv
// Shared definitions for the Gregorian date arithmetic pipeline:
// field widths, operation and status codes, calendar constants, reciprocals
// for the constant divisions, month tables. No dependencies.
package gda_pkg;

    // Field widths
    localparam int OP_W     = 3;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int AMOUNT_W = 23;
    localparam int DN_W     = 22;
    localparam int WDAY_W   = 3;
    localparam int YDAY_W   = 9;
    localparam int STATUS_W = 2;

    // Calendar limits
    localparam int unsigned DN_MAX     = 3652058;   // 9999-12-31
    localparam int unsigned YEAR_MAX   = 9999;
    localparam int unsigned MONTHS_MAX = 119999;    // 9999 * 12 + 11

    // Day counts of the Gregorian cycles
    localparam int unsigned DAYS_400Y = 146097;
    localparam int unsigned DAYS_100Y = 36524;
    localparam int unsigned DAYS_4Y   = 1461;
    localparam int unsigned DAYS_1Y   = 365;

    // Constant division by reciprocal: q = (x * K) >> S, with
    // S = input bits + ceil(log2(divisor)), exact over the whole input range.
    localparam int S_DIV100    = 21;   // 14-bit input
    localparam int S_DIV400    = 23;   // 14-bit input
    localparam int S_DIV12     = 21;   // 17-bit input
    localparam int S_DIV146097 = 40;   // 22-bit input
    localparam int S_DIV1461   = 27;   // 16-bit input
    localparam int S_DIV7      = 25;   // 22-bit input

    localparam logic [14:0] K_DIV100 =
        15'(((64'd1 << S_DIV100) + 64'd99) / 64'd100);
    localparam logic [14:0] K_DIV400 =
        15'(((64'd1 << S_DIV400) + 64'd399) / 64'd400);
    localparam logic [17:0] K_DIV12 =
        18'(((64'd1 << S_DIV12) + 64'd11) / 64'd12);
    localparam logic [22:0] K_DIV146097 =
        23'(((64'd1 << S_DIV146097) + 64'd146096) / 64'd146097);
    localparam logic [16:0] K_DIV1461 =
        17'(((64'd1 << S_DIV1461) + 64'd1460) / 64'd1461);
    localparam logic [22:0] K_DIV7 =
        23'(((64'd1 << S_DIV7) + 64'd6) / 64'd7);

    typedef enum logic [OP_W-1:0] {
        OP_ADD_DAYS   = 3'd0,
        OP_ADD_MONTHS = 3'd1,
        OP_ADD_YEARS  = 3'd2,
        OP_FROM_DN    = 3'd3,
        OP_QUERY      = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    // Item handed from the date-to-day-number front to the back end
    typedef struct packed {
        status_t          status;
        logic [DN_W-1:0]  dn;
    } dn_item_t;

    // Length of a month; zero for a month code outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of the year that lie before the first of month m
    function automatic logic [YDAY_W-1:0] cum_before(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [YDAY_W-1:0] days;
        unique case (m)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        if (leap && m > 4'd2)
        begin
            days = days + 9'd1;
        end
        return days;
    endfunction

endpackage

>>> rtl/core/gda_if.sv
// Valid/ready channel interfaces of the date arithmetic block:
// command items in, result items out.
// Depends on gda_pkg for the field widths.
interface gda_cmd_if import gda_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic [YEAR_W-1:0]          year;
    logic [MONTH_W-1:0]         month;
    logic [DAY_W-1:0]           day;
    logic signed [AMOUNT_W-1:0] amount;

    modport source (output valid, op, year, month, day, amount, input ready);
    modport sink   (input valid, op, year, month, day, amount, output ready);
endinterface

interface gda_res_if import gda_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   out_year;
    logic [MONTH_W-1:0]  out_month;
    logic [DAY_W-1:0]    out_day;
    logic [DN_W-1:0]     day_number;
    logic [WDAY_W-1:0]   weekday;
    logic [YDAY_W-1:0]   year_day;
    logic [STATUS_W-1:0] status;

    modport source (output valid, out_year, out_month, out_day, day_number,
                    weekday, year_day, status, input ready);
    modport sink   (input valid, out_year, out_month, out_day, day_number,
                    weekday, year_day, status, output ready);
endinterface

>>> rtl/core/gda_dn2date.sv
// Back end of the date pipeline: day number to year/month/day, weekday and
// day of year, eight register stages ending in the output register.
// Depends on gda_pkg and gda_res_if.
module gda_dn2date import gda_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  dn_item_t   up_item,
    gda_res_if.source  res
);

    typedef struct packed {
        status_t     status;
        logic [21:0] dn;
        logic [21:0] x1;     // dn + 1, for the weekday
        logic [4:0]  n400;
        logic [19:0] q7;
    } bs1_t;

    typedef struct packed {
        status_t     status;
        logic [21:0] dn;
        logic [2:0]  wd;
        logic [4:0]  n400;
        logic [17:0] r400;
    } bs2_t;

    typedef struct packed {
        status_t     status;
        logic [21:0] dn;
        logic [2:0]  wd;
        logic [4:0]  n400;
        logic [1:0]  n100;
        logic [15:0] r100;
    } bs3_t;

    typedef struct packed {
        status_t     status;
        logic [21:0] dn;
        logic [2:0]  wd;
        logic [4:0]  n400;
        logic [1:0]  n100;
        logic [15:0] r100;
        logic [4:0]  n4;
    } bs4_t;

    typedef struct packed {
        status_t     status;
        logic [21:0] dn;
        logic [2:0]  wd;
        logic [4:0]  n400;
        logic [1:0]  n100;
        logic [4:0]  n4;
        logic [10:0] r4;
    } bs5_t;

    typedef struct packed {
        status_t     status;
        logic [21:0] dn;
        logic [2:0]  wd;
        logic [4:0]  n400;
        logic [1:0]  n100;
        logic [4:0]  n4;
        logic [1:0]  n1;
        logic [8:0]  r1;     // day of year, from zero
        logic        leap;
    } bs6_t;

    typedef struct packed {
        status_t     status;
        logic [21:0] dn;
        logic [2:0]  wd;
        logic [13:0] year;
        logic [3:0]  month;
        logic [8:0]  r1;
        logic        leap;
    } bs7_t;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [21:0] day_number;
        logic [2:0]  weekday;
        logic [8:0]  year_day;
        status_t     status;
    } bs8_t;

    bs1_t b1_reg, b1_next;
    bs2_t b2_reg, b2_next;
    bs3_t b3_reg, b3_next;
    bs4_t b4_reg, b4_next;
    bs5_t b5_reg, b5_next;
    bs6_t b6_reg, b6_next;
    bs7_t b7_reg, b7_next;
    bs8_t b8_reg, b8_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8;

    // A stage loads when it is empty or its successor loads
    assign adv8     = !v8_reg || res.ready;
    assign adv7     = !v7_reg || adv8;
    assign adv6     = !v6_reg || adv7;
    assign adv5     = !v5_reg || adv6;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign up_ready = adv1;

    // Stage 1: 400-year cycles and weekday quotient
    always_comb
    begin
        logic [44:0] p400;
        logic [44:0] p7;
        logic [21:0] x1;
        x1             = up_item.dn + 22'd1;
        p400           = 45'(up_item.dn) * 45'(K_DIV146097);
        p7             = 45'(x1) * 45'(K_DIV7);
        b1_next.status = up_item.status;
        b1_next.dn     = up_item.dn;
        b1_next.x1     = x1;
        b1_next.n400   = p400[44:40];
        b1_next.q7     = p7[44:25];
    end

    // Stage 2: remainder in the 400-year cycle, weekday
    always_comb
    begin
        b2_next.status = b1_reg.status;
        b2_next.dn     = b1_reg.dn;
        b2_next.n400   = b1_reg.n400;
        b2_next.r400   = 18'(b1_reg.dn - 22'(b1_reg.n400) * 22'(DAYS_400Y));
        b2_next.wd     = 3'(b1_reg.x1 - 22'(b1_reg.q7) * 22'd7);
    end

    // Stage 3: centuries (the last one of a cycle is a day longer)
    always_comb
    begin
        logic [1:0] n100;
        priority if (b2_reg.r400 >= 18'(3 * DAYS_100Y))
        begin
            n100 = 2'd3;
        end
        else if (b2_reg.r400 >= 18'(2 * DAYS_100Y))
        begin
            n100 = 2'd2;
        end
        else if (b2_reg.r400 >= 18'(DAYS_100Y))
        begin
            n100 = 2'd1;
        end
        else
        begin
            n100 = 2'd0;
        end
        b3_next.status = b2_reg.status;
        b3_next.dn     = b2_reg.dn;
        b3_next.wd     = b2_reg.wd;
        b3_next.n400   = b2_reg.n400;
        b3_next.n100   = n100;
        b3_next.r100   = 16'(b2_reg.r400 - 18'(n100) * 18'(DAYS_100Y));
    end

    // Stage 4: 4-year groups
    always_comb
    begin
        logic [32:0] p4;
        p4             = 33'(b3_reg.r100) * 33'(K_DIV1461);
        b4_next.status = b3_reg.status;
        b4_next.dn     = b3_reg.dn;
        b4_next.wd     = b3_reg.wd;
        b4_next.n400   = b3_reg.n400;
        b4_next.n100   = b3_reg.n100;
        b4_next.r100   = b3_reg.r100;
        b4_next.n4     = p4[31:27];
    end

    // Stage 5: remainder in the 4-year group
    always_comb
    begin
        b5_next.status = b4_reg.status;
        b5_next.dn     = b4_reg.dn;
        b5_next.wd     = b4_reg.wd;
        b5_next.n400   = b4_reg.n400;
        b5_next.n100   = b4_reg.n100;
        b5_next.n4     = b4_reg.n4;
        b5_next.r4     = 11'(b4_reg.r100 - 16'(b4_reg.n4) * 16'(DAYS_4Y));
    end

    // Stage 6: single years, day of year and leap flag
    always_comb
    begin
        logic [1:0] n1;
        priority if (b5_reg.r4 >= 11'(3 * DAYS_1Y))
        begin
            n1 = 2'd3;
        end
        else if (b5_reg.r4 >= 11'(2 * DAYS_1Y))
        begin
            n1 = 2'd2;
        end
        else if (b5_reg.r4 >= 11'(DAYS_1Y))
        begin
            n1 = 2'd1;
        end
        else
        begin
            n1 = 2'd0;
        end
        b6_next.status = b5_reg.status;
        b6_next.dn     = b5_reg.dn;
        b6_next.wd     = b5_reg.wd;
        b6_next.n400   = b5_reg.n400;
        b6_next.n100   = b5_reg.n100;
        b6_next.n4     = b5_reg.n4;
        b6_next.n1     = n1;
        b6_next.r1     = 9'(b5_reg.r4 - 11'(n1) * 11'(DAYS_1Y));
        // fourth year of a group, unless it closes a non-leap century
        b6_next.leap   = (n1 == 2'd3) && ((b5_reg.n4 != 5'd24) || (b5_reg.n100 == 2'd3));
    end

    // Stage 7: year number and month search
    always_comb
    begin
        logic [3:0] mon;
        mon = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (b6_reg.r1 >= cum_before(4'(k), b6_reg.leap))
            begin
                mon = 4'(k);
            end
        end
        b7_next.status = b6_reg.status;
        b7_next.dn     = b6_reg.dn;
        b7_next.wd     = b6_reg.wd;
        b7_next.year   = 14'(b6_reg.n400) * 14'd400 + 14'(b6_reg.n100) * 14'd100
                       + 14'({b6_reg.n4, 2'b00}) + 14'(b6_reg.n1) + 14'd1;
        b7_next.month  = mon;
        b7_next.r1     = b6_reg.r1;
        b7_next.leap   = b6_reg.leap;
    end

    // Stage 8: day of month; fields read zero on any error
    always_comb
    begin
        logic ok;
        ok                 = (b7_reg.status == ST_OK);
        b8_next.status     = b7_reg.status;
        b8_next.out_year   = ok ? b7_reg.year : 14'd0;
        b8_next.out_month  = ok ? b7_reg.month : 4'd0;
        b8_next.out_day    = ok ? 5'(b7_reg.r1 - cum_before(b7_reg.month, b7_reg.leap)
                                     + 9'd1) : 5'd0;
        b8_next.day_number = ok ? b7_reg.dn : 22'd0;
        b8_next.weekday    = ok ? b7_reg.wd : 3'd0;
        b8_next.year_day   = ok ? b7_reg.r1 + 9'd1 : 9'd0;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= up_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
            if (adv6) v6_reg <= v5_reg;
            if (adv7) v7_reg <= v6_reg;
            if (adv8) v8_reg <= v7_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv1) b1_reg <= b1_next;
        if (adv2) b2_reg <= b2_next;
        if (adv3) b3_reg <= b3_next;
        if (adv4) b4_reg <= b4_next;
        if (adv5) b5_reg <= b5_next;
        if (adv6) b6_reg <= b6_next;
        if (adv7) b7_reg <= b7_next;
        if (adv8) b8_reg <= b8_next;
    end

    assign res.valid      = v8_reg;
    assign res.out_year   = b8_reg.out_year;
    assign res.out_month  = b8_reg.out_month;
    assign res.out_day    = b8_reg.out_day;
    assign res.day_number = b8_reg.day_number;
    assign res.weekday    = b8_reg.weekday;
    assign res.year_day   = b8_reg.year_day;
    assign res.status     = b8_reg.status;

endmodule

>>> rtl/core/gregorian_date_arithmetic.sv
// Gregorian date arithmetic, top level: validation, month/year shift with
// day clamp, date to day number and day offset, then the gda_dn2date back end.
// Depends on gda_pkg, gda_cmd_if, gda_res_if and gda_dn2date.
//
//   channel  dir  modport  payload
//   cmd      in   sink     op, year, month, day, amount
//   res      out  source   out_year, out_month, out_day, day_number,
//                          weekday, year_day, status
//
// Fifteen register stages: seven here, eight in the back end, the last being
// the output register. One item enters per cycle while res does not stall.
// Each stage has its own valid bit and loads when empty or when the next
// stage loads, so a stall at res holds every item in place and bubbles close.
// Reset (rst_n, asynchronous) clears the valid bits only.
module gregorian_date_arithmetic import gda_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    gda_cmd_if.sink    cmd,
    gda_res_if.source  res
);

    typedef struct packed {
        logic        is_days;
        logic        is_mon;
        logic        is_dn;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [22:0] amount;
        logic        base_ok;
        logic        amt_ok;
        logic [7:0]  yq100;
        logic [27:0] total;    // months since year 0, two's complement
    } fs1_t;

    typedef struct packed {
        logic        is_days;
        logic        is_mon;
        logic        is_dn;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [22:0] amount;
        logic        amt_ok;
        logic        in_ok;
        logic        leap_in;
        logic        mon_ok;
        logic [16:0] total;
        logic [13:0] ry;
    } fs2_t;

    typedef struct packed {
        logic        is_days;
        logic        is_mon;
        logic        is_dn;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [22:0] amount;
        logic        leap_in;
        logic [13:0] ry;
        logic [3:0]  rm;
        logic [7:0]  ryq100;
        status_t     status;
    } fs3_t;

    typedef struct packed {
        logic        is_days;
        logic        is_dn;
        logic [22:0] amount;
        status_t     status;
        logic [13:0] cy;
        logic [3:0]  cm;
        logic [4:0]  cd;
        logic        cleap;
    } fs4_t;

    typedef struct packed {
        logic        is_days;
        logic        is_dn;
        logic [22:0] amount;
        status_t     status;
        logic [21:0] base;
        logic [11:0] q4;
        logic [7:0]  q100;
        logic [5:0]  q400;
        logic [8:0]  doy0;
    } fs5_t;

    typedef struct packed {
        logic        is_days;
        logic        is_dn;
        logic [22:0] amount;
        status_t     status;
        logic [21:0] dn_date;
    } fs6_t;

    fs1_t     s1_reg, s1_next;
    fs2_t     s2_reg, s2_next;
    fs3_t     s3_reg, s3_next;
    fs4_t     s4_reg, s4_next;
    fs5_t     s5_reg, s5_next;
    fs6_t     s6_reg, s6_next;
    dn_item_t s7_reg, s7_next;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
    logic back_ready;

    // Stage advance chain
    assign adv7      = !v7_reg || back_ready;
    assign adv6      = !v6_reg || adv7;
    assign adv5      = !v5_reg || adv6;
    assign adv4      = !v4_reg || adv5;
    assign adv3      = !v3_reg || adv4;
    assign adv2      = !v2_reg || adv3;
    assign adv1      = !v1_reg || adv2;
    assign cmd.ready = adv1;

    // Stage 1: decode, field range checks, target month count, year / 100
    always_comb
    begin
        logic        is_years;
        logic [27:0] amt_ext;
        logic [27:0] amt_x12;
        logic [27:0] yr_x12;
        logic [28:0] p100;
        is_years        = (cmd.op == OP_ADD_YEARS);
        amt_ext         = {{5{cmd.amount[22]}}, cmd.amount};
        amt_x12         = (amt_ext << 3) + (amt_ext << 2);
        yr_x12          = 28'({cmd.year, 3'd0}) + 28'({cmd.year, 2'd0});
        p100            = 29'(cmd.year) * 29'(K_DIV100);
        s1_next.is_days = (cmd.op == OP_ADD_DAYS);
        s1_next.is_mon  = (cmd.op == OP_ADD_MONTHS) || is_years;
        s1_next.is_dn   = (cmd.op == OP_FROM_DN);
        s1_next.year    = cmd.year;
        s1_next.month   = cmd.month;
        s1_next.day     = cmd.day;
        s1_next.amount  = cmd.amount;
        s1_next.base_ok = (cmd.year >= 14'd1) && (cmd.year <= 14'(YEAR_MAX))
                       && (cmd.month >= 4'd1) && (cmd.month <= 4'd12)
                       && (cmd.day >= 5'd1);
        s1_next.amt_ok  = !cmd.amount[22] && (cmd.amount[21:0] <= 22'(DN_MAX));
        s1_next.yq100   = p100[28:21];
        s1_next.total   = yr_x12 + 28'(cmd.month) - 28'd1
                        + (is_years ? amt_x12 : amt_ext);
    end

    // Stage 2: leap year and day check of the input date, target year
    always_comb
    begin
        logic [13:0] yr100;
        logic        leap;
        logic [34:0] p12;
        yr100 = 14'({s1_reg.yq100, 6'd0}) + 14'({s1_reg.yq100, 5'd0})
              + 14'({s1_reg.yq100, 2'd0});
        leap  = (s1_reg.year[1:0] == 2'd0)
             && ((s1_reg.year != yr100) || (s1_reg.yq100[1:0] == 2'd0));
        p12   = 35'(s1_reg.total[16:0]) * 35'(K_DIV12);
        s2_next.is_days = s1_reg.is_days;
        s2_next.is_mon  = s1_reg.is_mon;
        s2_next.is_dn   = s1_reg.is_dn;
        s2_next.year    = s1_reg.year;
        s2_next.month   = s1_reg.month;
        s2_next.day     = s1_reg.day;
        s2_next.amount  = s1_reg.amount;
        s2_next.amt_ok  = s1_reg.amt_ok;
        s2_next.in_ok   = s1_reg.base_ok
                       && (s1_reg.day <= month_days(s1_reg.month, leap));
        s2_next.leap_in = leap;
        s2_next.mon_ok  = !s1_reg.total[27] && (s1_reg.total[26:0] >= 27'd12)
                       && (s1_reg.total[26:0] <= 27'(MONTHS_MAX));
        s2_next.total   = s1_reg.total[16:0];
        s2_next.ry      = p12[34:21];
    end

    // Stage 3: target month, target year / 100, status so far
    always_comb
    begin
        logic [16:0] ry12;
        logic [28:0] p100;
        status_t     st;
        ry12 = 17'({s2_reg.ry, 3'd0}) + 17'({s2_reg.ry, 2'd0});
        p100 = 29'(s2_reg.ry) * 29'(K_DIV100);
        priority if (s2_reg.is_dn)
        begin
            st = s2_reg.amt_ok ? ST_OK : ST_RANGE;
        end
        else if (!s2_reg.in_ok)
        begin
            st = ST_INVALID;
        end
        else if (s2_reg.is_mon && !s2_reg.mon_ok)
        begin
            st = ST_RANGE;
        end
        else
        begin
            st = ST_OK;
        end
        s3_next.is_days = s2_reg.is_days;
        s3_next.is_mon  = s2_reg.is_mon;
        s3_next.is_dn   = s2_reg.is_dn;
        s3_next.year    = s2_reg.year;
        s3_next.month   = s2_reg.month;
        s3_next.day     = s2_reg.day;
        s3_next.amount  = s2_reg.amount;
        s3_next.leap_in = s2_reg.leap_in;
        s3_next.ry      = s2_reg.ry;
        s3_next.rm      = 4'(s2_reg.total - ry12 + 17'd1);
        s3_next.ryq100  = p100[28:21];
        s3_next.status  = st;
    end

    // Stage 4: clamp the day to the target month, pick the date to convert
    always_comb
    begin
        logic [13:0] ry100;
        logic        leap_m;
        logic [4:0]  lim;
        logic [4:0]  rd;
        ry100  = 14'({s3_reg.ryq100, 6'd0}) + 14'({s3_reg.ryq100, 5'd0})
               + 14'({s3_reg.ryq100, 2'd0});
        leap_m = (s3_reg.ry[1:0] == 2'd0)
              && ((s3_reg.ry != ry100) || (s3_reg.ryq100[1:0] == 2'd0));
        lim    = month_days(s3_reg.rm, leap_m);
        rd     = (s3_reg.day > lim) ? lim : s3_reg.day;
        s4_next.is_days = s3_reg.is_days;
        s4_next.is_dn   = s3_reg.is_dn;
        s4_next.amount  = s3_reg.amount;
        s4_next.status  = s3_reg.status;
        s4_next.cy      = s3_reg.is_mon ? s3_reg.ry : s3_reg.year;
        s4_next.cm      = s3_reg.is_mon ? s3_reg.rm : s3_reg.month;
        s4_next.cd      = s3_reg.is_mon ? rd : s3_reg.day;
        s4_next.cleap   = s3_reg.is_mon ? leap_m : s3_reg.leap_in;
    end

    // Stage 5: terms of the day number of the chosen date
    always_comb
    begin
        logic [13:0] ym1;
        logic [28:0] p100;
        logic [28:0] p400;
        ym1  = s4_reg.cy - 14'd1;
        p100 = 29'(ym1) * 29'(K_DIV100);
        p400 = 29'(ym1) * 29'(K_DIV400);
        s5_next.is_days = s4_reg.is_days;
        s5_next.is_dn   = s4_reg.is_dn;
        s5_next.amount  = s4_reg.amount;
        s5_next.status  = s4_reg.status;
        s5_next.base    = 22'(ym1) * 22'(DAYS_1Y);
        s5_next.q4      = ym1[13:2];
        s5_next.q100    = p100[28:21];
        s5_next.q400    = p400[28:23];
        s5_next.doy0    = cum_before(s4_reg.cm, s4_reg.cleap) + 9'(s4_reg.cd) - 9'd1;
    end

    // Stage 6: day number of the chosen date
    always_comb
    begin
        s6_next.is_days = s5_reg.is_days;
        s6_next.is_dn   = s5_reg.is_dn;
        s6_next.amount  = s5_reg.amount;
        s6_next.status  = s5_reg.status;
        s6_next.dn_date = s5_reg.base + 22'(s5_reg.q4) - 22'(s5_reg.q100)
                        + 22'(s5_reg.q400) + 22'(s5_reg.doy0);
    end

    // Stage 7: day offset or direct day number, final range check
    always_comb
    begin
        logic [23:0] amt24;
        logic [23:0] date24;
        logic [23:0] sum;
        logic        bad;
        amt24  = {s6_reg.amount[22], s6_reg.amount};
        date24 = {2'b00, s6_reg.dn_date};
        priority if (s6_reg.is_dn)
        begin
            sum = amt24;
        end
        else if (s6_reg.is_days)
        begin
            sum = date24 + amt24;
        end
        else
        begin
            sum = date24;
        end
        bad            = sum[23] || (sum[22:0] > 23'(DN_MAX));
        s7_next.status = ((s6_reg.status == ST_OK) && bad) ? ST_RANGE : s6_reg.status;
        s7_next.dn     = sum[21:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= cmd.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
            if (adv6) v6_reg <= v5_reg;
            if (adv7) v7_reg <= v6_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
        if (adv4) s4_reg <= s4_next;
        if (adv5) s5_reg <= s5_next;
        if (adv6) s6_reg <= s6_next;
        if (adv7) s7_reg <= s7_next;
    end

    // Day number to date, weekday and day of year
    gda_dn2date u_dn2date (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v7_reg),
        .up_ready (back_ready),
        .up_item  (s7_reg),
        .res      (res)
    );

endmodule
